@@ src/mam_pkg.sv @@
package mam_pkg;

   // table size default
   localparam int ALARM_SLOTS_DEF = 8;

   // request modes
   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_SET    = 3'd1;
   localparam logic [2:0] MODE_DELETE = 3'd2;
   localparam logic [2:0] MODE_TOGGLE = 3'd3;
   localparam logic [2:0] MODE_SNOOZE = 3'd4;

   // response status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_FREE    = 3'd1;
   localparam logic [2:0] ST_BAD_TIME   = 3'd2;
   localparam logic [2:0] ST_BAD_REPEAT = 3'd3;
   localparam logic [2:0] ST_BAD_SLOT   = 3'd4;
   localparam logic [2:0] ST_EMPTY      = 3'd5;

   // repeat types
   localparam logic [1:0] REP_NONE     = 2'd0;
   localparam logic [1:0] REP_ONCE     = 2'd1;
   localparam logic [1:0] REP_DAILY    = 2'd2;
   localparam logic [1:0] REP_WEEKDAYS = 2'd3;

   // clock arithmetic
   localparam logic [6:0] SNOOZE_MIN     = 7'd5;
   localparam logic [6:0] MIN_PER_HOUR   = 7'd60;
   localparam logic [4:0] HOUR_PER_DAY   = 5'd24;
   localparam logic [2:0] DAY_SUNDAY     = 3'd0;
   localparam logic [2:0] DAY_SATURDAY   = 3'd6;

   // one alarm slot
   typedef struct packed {
      logic       in_use;
      logic [4:0] hour;
      logic [5:0] minute;
      logic       enabled;
      logic [1:0] repeat_kind;
      logic       fired;
   } slot_entry_type;

   // result of evaluating one slot against the held request
   typedef struct packed {
      logic           fire;
      slot_entry_type entry;
   } slot_eval_type;

endpackage

@@ src/mam_slot_table.sv @@
module mam_slot_table
   import mam_pkg::*;
#(
   parameter int ALARM_SLOTS = ALARM_SLOTS_DEF,
   parameter int IDX_W       = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     idx,
   input  logic                 wr_en,
   input  slot_entry_type       wr_data,
   output slot_entry_type       rd_data
);

   logic             in_use_ff  [ALARM_SLOTS];
   logic [4:0]       hour_ff    [ALARM_SLOTS];
   logic [5:0]       minute_ff  [ALARM_SLOTS];
   logic             enabled_ff [ALARM_SLOTS];
   logic [1:0]       repeat_ff  [ALARM_SLOTS];
   logic             fired_ff   [ALARM_SLOTS];

   // flags cleared and repeat type set to once at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALARM_SLOTS; i++) begin
            in_use_ff[i]  <= 1'b0;
            enabled_ff[i] <= 1'b0;
            fired_ff[i]   <= 1'b0;
            repeat_ff[i]  <= REP_ONCE;
         end
      end else if (wr_en) begin
         in_use_ff[idx]  <= wr_data.in_use;
         enabled_ff[idx] <= wr_data.enabled;
         fired_ff[idx]   <= wr_data.fired;
         repeat_ff[idx]  <= wr_data.repeat_kind;
      end
   end

   // alarm time, undefined until a set writes it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hour_ff[idx]   <= wr_data.hour;
         minute_ff[idx] <= wr_data.minute;
      end
   end

   // read of the addressed slot
   always_comb begin
      rd_data.in_use      = in_use_ff[idx];
      rd_data.hour        = hour_ff[idx];
      rd_data.minute      = minute_ff[idx];
      rd_data.enabled     = enabled_ff[idx];
      rd_data.repeat_kind = repeat_ff[idx];
      rd_data.fired       = fired_ff[idx];
   end

endmodule

@@ src/mam_slot_eval.sv @@
module mam_slot_eval
   import mam_pkg::*;
(
   input  logic [2:0]     mode,
   input  logic [4:0]     hour,
   input  logic [5:0]     minute,
   input  logic [2:0]     weekday,
   input  logic [1:0]     repeat_req,
   input  slot_entry_type cur,
   output slot_eval_type  res
);

   logic       weekend;
   logic       match;
   logic       fire;
   logic [6:0] snz_sum;
   logic [5:0] snz_min;
   logic [4:0] hour_inc;
   logic [4:0] snz_hour;

   // match of the slot against the current time
   assign weekend = (weekday == DAY_SUNDAY) || (weekday == DAY_SATURDAY);
   assign match   = (cur.hour == hour) && (cur.minute == minute);
   assign fire    = cur.enabled && !cur.fired && match
                    && !((cur.repeat_kind == REP_WEEKDAYS) && weekend);

   // snooze arithmetic with minute and hour wrap
   assign snz_sum  = {1'b0, cur.minute} + SNOOZE_MIN;
   assign hour_inc = (cur.hour + 5'd1 >= HOUR_PER_DAY) ? 5'd0 : cur.hour + 5'd1;
   always_comb begin
      if (snz_sum >= MIN_PER_HOUR) begin
         snz_min  = 6'(snz_sum - MIN_PER_HOUR);
         snz_hour = hour_inc;
      end else begin
         snz_min  = snz_sum[5:0];
         snz_hour = cur.hour;
      end
   end

   // next slot contents per mode
   always_comb begin
      res.fire  = 1'b0;
      res.entry = cur;
      unique case (mode)
         MODE_TICK: begin
            res.fire = fire;
            if (fire) begin
               res.entry.fired = 1'b1;
               if (cur.repeat_kind == REP_ONCE) begin
                  res.entry.enabled = 1'b0;
               end
            end
            // repeating slots re-arm once the minute has moved on
            if ((cur.repeat_kind != REP_ONCE) && (cur.minute != minute)) begin
               res.entry.fired = 1'b0;
            end
         end
         MODE_SET: begin
            res.entry.in_use      = 1'b1;
            res.entry.hour        = hour;
            res.entry.minute      = minute;
            res.entry.enabled     = 1'b1;
            res.entry.repeat_kind = repeat_req;
            res.entry.fired       = 1'b0;
         end
         MODE_DELETE: begin
            res.entry.in_use  = 1'b0;
            res.entry.enabled = 1'b0;
            res.entry.fired   = 1'b0;
         end
         MODE_TOGGLE: begin
            res.entry.enabled = !cur.enabled;
            if (!cur.enabled) begin
               res.entry.fired = 1'b0;
            end
         end
         MODE_SNOOZE: begin
            res.entry.hour    = snz_hour;
            res.entry.minute  = snz_min;
            res.entry.enabled = 1'b1;
            res.entry.fired   = 1'b0;
         end
         default: begin
            res.entry = cur;
         end
      endcase
   end

endmodule

@@ src/multi_slot_alarm_matcher.sv @@
// Alarm table with ALARM_SLOTS slots, driven by one request at a time.
// Request channel: req_mode selects tick, set, delete, toggle or snooze; the
// request is taken on a rising edge with start high and busy low; busy then
// stays high until its response is produced, except for a bad slot or mode.
// Response channel: rsp_valid is high for exactly one cycle with status, slot,
// fired mask, fired flag and last fired slot; the receiver cannot stall it.
// Steps from the taking of a request to rsp_valid:
//   tick: every slot in turn, one slot read, evaluated and written back
//         per cycle through the shared slot evaluator
//   set: scans for the lowest free slot and writes it if the request is valid
//   delete, toggle, snooze: edit state; bad slot or unknown mode: idle only
// A new request may be started in the cycle in which rsp_valid is high.
// Reset leaves all slots free, disabled and unfired, with no response pending.
module multi_slot_alarm_matcher
   import mam_pkg::*;
#(
   parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_mode,
   input  logic [4:0] req_hour,
   input  logic [5:0] req_minute,
   input  logic [2:0] req_weekday,
   input  logic [2:0] req_slot,
   input  logic [1:0] req_repeat_req,
   output logic       rsp_valid,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_slot_used,
   output logic [7:0] rsp_fired_mask,
   output logic       rsp_fired_any,
   output logic [2:0] rsp_last_fired
);

   localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALARM_SLOTS - 1);
   localparam logic [4:0] SLOTS_LIM = 5'(ALARM_SLOTS);
   localparam logic [4:0] MASK_SLOTS = 5'd8;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TICK = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_EDIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]       mode_ff, mode_in;
   logic [4:0]       hour_ff, hour_in;
   logic [5:0]       minute_ff, minute_in;
   logic [2:0]       weekday_ff, weekday_in;
   logic [1:0]       repeat_ff, repeat_in;
   logic [7:0]       mask_ff, mask_in;
   logic [2:0]       last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [2:0]       rsp_used_ff, rsp_used_in;
   logic [7:0]       rsp_mask_ff, rsp_mask_in;
   logic [2:0]       rsp_last_ff, rsp_last_in;

   logic             wr_en;
   slot_entry_type   rd_entry;
   slot_eval_type    eval;
   logic             time_ok;
   logic [2:0]       idx_low;
   logic             idx_in_mask;

   // slot storage
   mam_slot_table #(
      .ALARM_SLOTS (ALARM_SLOTS),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .idx     (idx_ff),
      .wr_en   (wr_en),
      .wr_data (eval.entry),
      .rd_data (rd_entry)
   );

   // shared slot evaluator
   mam_slot_eval u_eval (
      .mode       (mode_ff),
      .hour       (hour_ff),
      .minute     (minute_ff),
      .weekday    (weekday_ff),
      .repeat_req (repeat_ff),
      .cur        (rd_entry),
      .res        (eval)
   );

   assign time_ok     = (hour_ff < HOUR_PER_DAY) && ({1'b0, minute_ff} < MIN_PER_HOUR);
   assign idx_low     = 3'(idx_ff);
   assign idx_in_mask = 5'(idx_ff) < MASK_SLOTS;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      mode_in       = mode_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      weekday_in    = weekday_ff;
      repeat_in     = repeat_ff;
      mask_in       = mask_ff;
      last_in       = last_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in       = req_mode;
               hour_in       = req_hour;
               minute_in     = req_minute;
               weekday_in    = req_weekday;
               repeat_in     = req_repeat_req;
               idx_in        = '0;
               mask_in       = '0;
               last_in       = '0;
               rsp_status_in = ST_OK;
               rsp_used_in   = '0;
               rsp_mask_in   = '0;
               rsp_last_in   = '0;
               unique case (req_mode) inside
                  MODE_TICK: begin
                     state_in = S_TICK;
                  end
                  MODE_SET: begin
                     state_in = S_SCAN;
                  end
                  MODE_DELETE, MODE_TOGGLE, MODE_SNOOZE: begin
                     rsp_used_in = req_slot;
                     if ({2'b00, req_slot} >= SLOTS_LIM) begin
                        rsp_status_in = ST_BAD_SLOT;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        idx_in   = IDX_W'(req_slot);
                        state_in = S_EDIT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         // one slot per cycle: evaluate and write back
         S_TICK: begin
            wr_en = 1'b1;
            if (eval.fire) begin
               last_in = idx_low;
               if (idx_in_mask) begin
                  mask_in = mask_ff | (8'd1 << idx_low);
               end
            end
            if (idx_ff == IDX_LAST) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_in;
               rsp_last_in  = last_in;
               state_in     = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         // search for the lowest free slot
         S_SCAN: begin
            if (!rd_entry.in_use) begin
               if (!time_ok) begin
                  rsp_status_in = ST_BAD_TIME;
               end else if (repeat_ff == REP_NONE) begin
                  rsp_status_in = ST_BAD_REPEAT;
               end else begin
                  wr_en       = 1'b1;
                  rsp_used_in = idx_low;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (idx_ff == IDX_LAST) begin
               rsp_status_in = ST_NO_FREE;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         // delete, toggle or snooze of the addressed slot
         S_EDIT: begin
            if (!rd_entry.in_use) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               wr_en = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      mode_ff       <= mode_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      weekday_ff    <= weekday_in;
      repeat_ff     <= repeat_in;
      mask_ff       <= mask_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_used  = rsp_used_ff;
   assign rsp_fired_mask = rsp_mask_ff;
   assign rsp_fired_any  = |rsp_mask_ff;
   assign rsp_last_fired = rsp_last_ff;

endmodule

@@ tb/sv/multi_slot_alarm_matcher_tb.sv @@
`timescale 1ns / 1ps

module multi_slot_alarm_matcher_tb;
   import mam_pkg::*;

   localparam int SLOTS      = ALARM_SLOTS_DEF;
   localparam int N_RANDOM   = 1400;
   localparam int N_CALM_END = 150;

   // one request as driven on the req_ ports
   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [2:0] weekday;
      logic [2:0] slot;
      logic [1:0] rep;
   } alarm_req_type;

   // one response as seen on the rsp_ ports
   typedef struct packed {
      logic [2:0] status;
      logic [2:0] slot_used;
      logic [7:0] fired_mask;
      logic       fired_any;
      logic [2:0] last_fired;
   } alarm_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_mode = '0;
   logic [4:0] req_hour = '0;
   logic [5:0] req_minute = '0;
   logic [2:0] req_weekday = '0;
   logic [2:0] req_slot = '0;
   logic [1:0] req_repeat_req = '0;
   logic       rsp_valid;
   logic [2:0] rsp_status;
   logic [2:0] rsp_slot_used;
   logic [7:0] rsp_fired_mask;
   logic       rsp_fired_any;
   logic [2:0] rsp_last_fired;

   alarm_req_type  pending_requests[$];
   alarm_rsp_type  awaited_responses[$];
   slot_entry_type shadow_slots[SLOTS];
   alarm_req_type  held_request;
   int             err_count = 0;
   bit             calm = 1'b0;
   int             gap_left = 0;

   multi_slot_alarm_matcher #(
      .ALARM_SLOTS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_hour(req_hour),
      .req_minute(req_minute),
      .req_weekday(req_weekday),
      .req_slot(req_slot),
      .req_repeat_req(req_repeat_req),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_slot_used(rsp_slot_used),
      .rsp_fired_mask(rsp_fired_mask),
      .rsp_fired_any(rsp_fired_any),
      .rsp_last_fired(rsp_last_fired)
   );

   always #5 clock = ~clock;

   // table contents after reset
   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         shadow_slots[i] = '0;
         shadow_slots[i].repeat_kind = REP_ONCE;
      end
   end

   // applies one request to the shadow table and returns its response
   function automatic alarm_rsp_type predict_alarm_response(alarm_req_type rq);
      alarm_rsp_type r;
      int            i;
      int            idx;
      bit            found;
      logic [6:0]    m;
      logic [4:0]    h;
      r = '0;
      idx = 0;
      found = 1'b0;
      case (rq.mode) inside
         MODE_TICK: begin
            // match pass
            for (i = 0; i < SLOTS; i++) begin
               if (shadow_slots[i].enabled && !shadow_slots[i].fired &&
                   shadow_slots[i].hour == rq.hour && shadow_slots[i].minute == rq.minute &&
                   !(shadow_slots[i].repeat_kind == REP_WEEKDAYS &&
                     (rq.weekday == DAY_SUNDAY || rq.weekday == DAY_SATURDAY))) begin
                  shadow_slots[i].fired = 1'b1;
                  if (shadow_slots[i].repeat_kind == REP_ONCE)
                     shadow_slots[i].enabled = 1'b0;
                  if (i < 8)
                     r.fired_mask[i] = 1'b1;
                  r.last_fired = i[2:0];
               end
            end
            // repeating slots re-arm once the minute has moved on
            for (i = 0; i < SLOTS; i++) begin
               if (shadow_slots[i].repeat_kind != REP_ONCE &&
                   shadow_slots[i].minute != rq.minute)
                  shadow_slots[i].fired = 1'b0;
            end
            r.fired_any = (r.fired_mask != 8'd0);
         end
         MODE_SET: begin
            for (i = 0; i < SLOTS; i++) begin
               if (!found && !shadow_slots[i].in_use) begin
                  idx = i;
                  found = 1'b1;
               end
            end
            if (!found)
               r.status = ST_NO_FREE;
            else if (rq.hour >= HOUR_PER_DAY || {1'b0, rq.minute} >= MIN_PER_HOUR)
               r.status = ST_BAD_TIME;
            else if (rq.rep == REP_NONE)
               r.status = ST_BAD_REPEAT;
            else begin
               shadow_slots[idx].in_use      = 1'b1;
               shadow_slots[idx].hour        = rq.hour;
               shadow_slots[idx].minute      = rq.minute;
               shadow_slots[idx].enabled     = 1'b1;
               shadow_slots[idx].repeat_kind = rq.rep;
               shadow_slots[idx].fired       = 1'b0;
               r.slot_used = idx[2:0];
            end
         end
         MODE_DELETE, MODE_TOGGLE, MODE_SNOOZE: begin
            r.slot_used = rq.slot;
            if (int'(rq.slot) >= SLOTS)
               r.status = ST_BAD_SLOT;
            else if (!shadow_slots[rq.slot].in_use)
               r.status = ST_EMPTY;
            else if (rq.mode == MODE_DELETE) begin
               shadow_slots[rq.slot].in_use  = 1'b0;
               shadow_slots[rq.slot].enabled = 1'b0;
               shadow_slots[rq.slot].fired   = 1'b0;
            end else if (rq.mode == MODE_TOGGLE) begin
               if (shadow_slots[rq.slot].enabled)
                  shadow_slots[rq.slot].enabled = 1'b0;
               else begin
                  shadow_slots[rq.slot].enabled = 1'b1;
                  shadow_slots[rq.slot].fired   = 1'b0;
               end
            end else begin
               // snooze with minute and hour wrap
               m = {1'b0, shadow_slots[rq.slot].minute} + SNOOZE_MIN;
               h = shadow_slots[rq.slot].hour;
               if (m >= MIN_PER_HOUR) begin
                  m = m - MIN_PER_HOUR;
                  h = h + 5'd1;
                  if (h >= HOUR_PER_DAY)
                     h = 5'd0;
               end
               shadow_slots[rq.slot].minute  = m[5:0];
               shadow_slots[rq.slot].hour    = h;
               shadow_slots[rq.slot].enabled = 1'b1;
               shadow_slots[rq.slot].fired   = 1'b0;
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // request driver, predicts each request as it is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the request until it is taken
      end else begin
         if (start)
            awaited_responses.push_back(predict_alarm_response(held_request));
         if (start && !calm && $urandom_range(0, 9) < 3)
            gap_left = $urandom_range(1, 4);
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            held_request = pending_requests.pop_front();
            req_mode       <= held_request.mode;
            req_hour       <= held_request.hour;
            req_minute     <= held_request.minute;
            req_weekday    <= held_request.weekday;
            req_slot       <= held_request.slot;
            req_repeat_req <= held_request.rep;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      alarm_rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_responses.size() == 0) begin
            $error("response with no request outstanding");
            err_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               err_count++;
            end
            if (rsp_slot_used !== want.slot_used) begin
               $error("slot_used: expected %0d, got %0d", want.slot_used, rsp_slot_used);
               err_count++;
            end
            if (rsp_fired_mask !== want.fired_mask) begin
               $error("fired_mask: expected %h, got %h", want.fired_mask, rsp_fired_mask);
               err_count++;
            end
            if (rsp_fired_any !== want.fired_any) begin
               $error("fired_any: expected %0d, got %0d", want.fired_any, rsp_fired_any);
               err_count++;
            end
            if (rsp_last_fired !== want.last_fired) begin
               $error("last_fired: expected %0d, got %0d", want.last_fired, rsp_last_fired);
               err_count++;
            end
         end
      end
   end

   function automatic alarm_req_type make_req(logic [2:0] md, logic [4:0] hr, logic [5:0] mn,
                                             logic [2:0] wd, logic [2:0] sl, logic [1:0] rp);
      alarm_req_type rq;
      rq = '{mode: md, hour: hr, minute: mn, weekday: wd, slot: sl, rep: rp};
      return rq;
   endfunction

   // keep the queue short so the generator sees a nearly current table
   task automatic queue_request(input alarm_req_type rq);
      while (pending_requests.size() > 1)
         @(negedge clock);
      pending_requests.push_back(rq);
   endtask

   // stimulus: directed requests, then random traffic
   initial begin
      alarm_req_type rq;
      alarm_req_type last_tick;
      int            k;
      int            sel;
      int            idx;
      int            settle;
      last_tick = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // a tick, then bad set requests on an empty table
      queue_request(make_req(MODE_TICK, 5'd0, 6'd0, 3'd0, 3'd0, 2'd0));
      queue_request(make_req(MODE_SET, 5'd31, 6'd0, 3'd0, 3'd0, REP_ONCE));
      queue_request(make_req(MODE_SET, 5'd0, 6'd63, 3'd7, 3'd7, REP_ONCE));
      queue_request(make_req(MODE_SET, 5'd24, 6'd0, 3'd0, 3'd0, REP_DAILY));
      queue_request(make_req(MODE_SET, 5'd0, 6'd60, 3'd0, 3'd0, REP_DAILY));
      queue_request(make_req(MODE_SET, 5'd5, 6'd5, 3'd0, 3'd0, REP_NONE));
      // one slot of each repeat type
      queue_request(make_req(MODE_SET, 5'd0, 6'd0, 3'd0, 3'd0, REP_ONCE));
      queue_request(make_req(MODE_SET, 5'd23, 6'd59, 3'd0, 3'd0, REP_DAILY));
      queue_request(make_req(MODE_SET, 5'd12, 6'd30, 3'd0, 3'd0, REP_WEEKDAYS));
      // once slot fires and disables, weekday slot skips the weekend
      queue_request(make_req(MODE_TICK, 5'd0, 6'd0, 3'd3, 3'd0, 2'd0));
      queue_request(make_req(MODE_TICK, 5'd0, 6'd0, 3'd3, 3'd0, 2'd0));
      queue_request(make_req(MODE_TICK, 5'd12, 6'd30, DAY_SUNDAY, 3'd0, 2'd0));
      queue_request(make_req(MODE_TICK, 5'd12, 6'd30, DAY_SATURDAY, 3'd0, 2'd0));
      queue_request(make_req(MODE_TICK, 5'd12, 6'd30, 3'd7, 3'd0, 2'd0));
      queue_request(make_req(MODE_TICK, 5'd12, 6'd30, 3'd7, 3'd0, 2'd0));
      queue_request(make_req(MODE_TICK, 5'd12, 6'd31, 3'd1, 3'd0, 2'd0));
      // edits: toggle both ways, snooze across midnight, empty slots
      queue_request(make_req(MODE_TOGGLE, 5'd0, 6'd0, 3'd0, 3'd0, 2'd0));
      queue_request(make_req(MODE_TOGGLE, 5'd0, 6'd0, 3'd0, 3'd1, 2'd0));
      queue_request(make_req(MODE_SNOOZE, 5'd0, 6'd0, 3'd0, 3'd1, 2'd0));
      queue_request(make_req(MODE_SNOOZE, 5'd0, 6'd0, 3'd0, 3'd7, 2'd0));
      queue_request(make_req(MODE_DELETE, 5'd0, 6'd0, 3'd0, 3'd6, 2'd0));
      queue_request(make_req(MODE_DELETE, 5'd0, 6'd0, 3'd0, 3'd2, 2'd0));
      // two slots firing on one tick
      queue_request(make_req(MODE_SET, 5'd0, 6'd4, 3'd0, 3'd0, REP_DAILY));
      queue_request(make_req(MODE_TICK, 5'd0, 6'd4, 3'd2, 3'd0, 2'd0));
      // unknown modes
      queue_request(make_req(3'd5, 5'd31, 6'd63, 3'd7, 3'd7, 2'd3));
      queue_request(make_req(3'd6, 5'd0, 6'd0, 3'd0, 3'd0, 2'd0));
      queue_request(make_req(3'd7, 5'd1, 6'd1, 3'd1, 3'd1, 2'd1));
      // fill the table, then a set on a full table with a bad time too
      for (k = 0; k < 5; k++)
         queue_request(make_req(MODE_SET, 5'd23, 6'd59, 3'd0, 3'd0, REP_ONCE));
      queue_request(make_req(MODE_SET, 5'd31, 6'd63, 3'd0, 3'd0, REP_NONE));

      // random traffic, mostly well formed against the current table
      for (k = 0; k < N_RANDOM; k++) begin
         if (k % 100 == 0)
            calm = (k >= N_RANDOM - N_CALM_END) || ($urandom_range(0, 3) == 0);
         if (k == N_RANDOM / 2) begin
            // let the block drain completely before going on
            while (pending_requests.size() != 0 || start || awaited_responses.size() != 0)
               @(negedge clock);
         end
         rq = make_req(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                       6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                       3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
         sel = $urandom_range(0, 99);
         idx = $urandom_range(0, SLOTS - 1);
         if (sel < 40) begin
            rq.mode = MODE_TICK;
            if ($urandom_range(0, 99) < 15)
               rq = last_tick;
            else if (shadow_slots[idx].in_use && $urandom_range(0, 9) < 8) begin
               rq.hour   = shadow_slots[idx].hour;
               rq.minute = shadow_slots[idx].minute;
               if ($urandom_range(0, 3) == 0)
                  rq.minute = (shadow_slots[idx].minute == 6'd59) ? 6'd0
                                                                  : shadow_slots[idx].minute + 6'd1;
            end
            last_tick = rq;
         end else if (sel < 58) begin
            rq.mode = MODE_SET;
            if ($urandom_range(0, 99) < 85) begin
               // few distinct times so that slots share a time
               case ($urandom_range(0, 3))
                  0: rq.hour = 5'd0;
                  1: rq.hour = 5'd23;
                  2: rq.hour = 5'd12;
                  default: rq.hour = 5'($urandom_range(0, 23));
               endcase
               case ($urandom_range(0, 4))
                  0: rq.minute = 6'd0;
                  1: rq.minute = 6'd55;
                  2: rq.minute = 6'd59;
                  3: rq.minute = 6'd30;
                  default: rq.minute = 6'($urandom_range(0, 59));
               endcase
               rq.rep = 2'($urandom_range(1, 3));
            end
         end else if (sel < 72) begin
            rq.mode = MODE_DELETE;
         end else if (sel < 82) begin
            rq.mode = MODE_TOGGLE;
         end else if (sel < 92) begin
            rq.mode = MODE_SNOOZE;
         end else if (sel < 95) begin
            rq.mode = 3'($urandom_range(5, 7));
         end else begin
            rq.mode = MODE_TICK;
         end
         queue_request(rq);
      end

      // drain, then watch for stray responses
      while (pending_requests.size() != 0 || start || awaited_responses.size() != 0)
         @(negedge clock);
      for (settle = 0; settle < 4 * (SLOTS + 1); settle++)
         @(negedge clock);
      if (awaited_responses.size() != 0) begin
         $error("%0d responses never arrived", awaited_responses.size());
         err_count++;
      end
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
